[rtl/mse_pkg.sv]
// Shared types and constants for the merge sort engine.
// No dependencies; imported by mse_cell and merge_sort_engine_top.
`default_nettype none
package mse_pkg;

  localparam int DW = 32;

  typedef struct packed {
    logic                 valid;
    logic                 gt;
    logic signed [DW-1:0] data;
  } link_t;

  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_LOAD  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

endpackage
`default_nettype wire

[rtl/mse_cell.sv]
// One sorting cell: holds one element, inserts in order, shifts toward the head.
// Depends on mse_pkg.
`default_nettype none
module mse_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mse_pkg::cell_ctl_t           ctl,
  input  wire logic signed [mse_pkg::DW-1:0] new_value,
  input  wire mse_pkg::link_t               left,
  input  wire mse_pkg::link_t               right,
  output mse_pkg::link_t                    own
);
  import mse_pkg::*;

  logic                 valid;
  logic signed [DW-1:0] data;
  logic                 gt;
  logic                 take;

  assign gt   = valid && (data > new_value);
  assign take = gt || (!valid && left.valid);

  assign own.valid = valid;
  assign own.gt    = gt;
  assign own.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shl) begin
      valid <= right.valid;
    end else if (ctl.ins && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shl) begin
      data <= right.data;
    end else if (ctl.ins && take) begin
      data <= left.gt ? left.data : new_value;
    end
  end

endmodule
`default_nettype wire

[rtl/merge_sort_engine_top.sv]
// Sort engine top level (insertion sort, despite the name): a row of insertion cells plus load/drain control.
// Depends on mse_pkg and mse_cell.
// Loading accepts one item per cycle; the first result is offered the cycle after
// the last item, then one result per cycle while out_ready is high. These rates are
// set by the single-step insert/shift of the cell row. Reset (synchronous, rst)
// empties the row, clears the count and overflow flag, and returns to loading.
`default_nettype none
module merge_sort_engine_top #(
  parameter int MAX_ELEMS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [mse_pkg::DW-1:0] value,
  input  wire logic                         last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [mse_pkg::DW-1:0]     sorted_value,
  output logic                              end_of_list,
  output logic                              dropped
);
  import mse_pkg::*;

  localparam int CW = $clog2(MAX_ELEMS + 1);

  state_t        state;
  logic [CW-1:0] count;
  logic          overflow;
  logic          in_acc;
  logic          out_acc;
  logic          full;
  cell_ctl_t     ctl;
  link_t         links [MAX_ELEMS+2];

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_DRAIN);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign full      = (count == CW'(MAX_ELEMS));

  assign ctl.ins = in_acc && !full;
  assign ctl.shl = out_acc;

  assign links[0].valid         = 1'b1;
  assign links[0].gt            = 1'b0;
  assign links[0].data          = '0;
  assign links[MAX_ELEMS+1].valid = 1'b0;
  assign links[MAX_ELEMS+1].gt    = 1'b0;
  assign links[MAX_ELEMS+1].data  = '0;

  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    mse_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_value (value),
      .left      (links[i]),
      .right     (links[i+2]),
      .own       (links[i+1])
    );
  end

  assign sorted_value = links[1].data;
  assign end_of_list  = (count == CW'(1));
  assign dropped      = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (last) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (out_acc) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state    <= S_LOAD;
              overflow <= 1'b0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0) && links[1].valid)
    else $error("drain with empty cell row");

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("load and drain active together");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (in_ready && overflow) |-> full)
    else $error("overflow flagged while row not full");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (out_acc && end_of_list) |=> in_ready && !links[1].valid && (count == '0))
    else $error("cell row not empty after final result");

endmodule
`default_nettype wire
